FILE: rtl/core/http_header_field_tokenizer_macros.svh
// Assertion helpers shared by the tokenizer RTL
`ifndef HTTP_HEADER_FIELD_TOKENIZER_MACROS_SVH
`define HTTP_HEADER_FIELD_TOKENIZER_MACROS_SVH

// same-cycle implication
`define HTOK_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTOK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/htok_pkg.sv
package htok_pkg;

  localparam int unsigned POS_W = 16;
  localparam int unsigned LEN_W = 9;

  localparam logic [POS_W-1:0] BLOCK_LIMIT = 16'hFFFF;

  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_COLON = 8'd58;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;

  localparam logic [LEN_W-1:0] MAX_FIELD_RESET = 9'd511;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_FIELD  = 3'd0;
  localparam kind_t KIND_END    = 3'd1;
  localparam kind_t KIND_SYNTAX = 3'd2;
  localparam kind_t KIND_LONG   = 3'd3;
  localparam kind_t KIND_BLOCK  = 3'd4;

  typedef enum logic [5:0] {
    PH_LEAD     = 6'b000001,
    PH_KEY      = 6'b000010,
    PH_PRECOLON = 6'b000100,
    PH_PREVALUE = 6'b001000,
    PH_VALUE    = 6'b010000,
    PH_ERROR    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [POS_W-1:0] key_offset;
    logic [LEN_W-1:0] key_length;
    logic [POS_W-1:0] value_offset;
    logic [LEN_W-1:0] value_length;
    logic [POS_W-1:0] consumed_count;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       restart;
  } beat_t;

endpackage

FILE: rtl/core/htok_in_stage.sv
module htok_in_stage import htok_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_restart,
  input  logic       adv,
  output beat_t      beat
);

  logic       v_r;
  logic       v_nxt;
  logic [7:0] data_r;
  logic       restart_r;
  logic       take;

  assign in_stall = v_r && !adv;
  assign take     = in_valid && !in_stall;
  assign v_nxt    = take || (v_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r    <= in_data_byte;
      restart_r <= in_restart;
    end
  end

  assign beat.valid     = v_r;
  assign beat.data_byte = data_r;
  assign beat.restart   = restart_r;

endmodule

FILE: rtl/core/htok_parse.sv
module htok_parse import htok_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  beat_t            beat,
  input  logic [LEN_W-1:0] limit,
  output res_t             res
);

  phase_t           phase_r, phase_nxt, phase_c;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_c;
  logic [POS_W-1:0] kstart_r, kstart_nxt, kstart_c;
  logic [LEN_W-1:0] kcount_r, kcount_nxt, kcount_c;
  logic [POS_W-1:0] vstart_r, vstart_nxt, vstart_c;
  logic [POS_W-1:0] vlast_r, vlast_nxt, vlast_c;
  logic [7:0]       c;
  logic             is_lf;
  logic             is_colon;
  logic             is_ws;
  logic [POS_W-1:0] vdiff;
  logic [POS_W-1:0] vspan;

  assign c        = beat.data_byte;
  assign is_lf    = (c == CHAR_LF);
  assign is_colon = (c == CHAR_COLON);
  assign is_ws    = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));

  always_comb begin
    phase_c  = beat.restart ? PH_LEAD : phase_r;
    pos_c    = beat.restart ? '0 : pos_r;
    kstart_c = beat.restart ? '0 : kstart_r;
    kcount_c = beat.restart ? '0 : kcount_r;
    vstart_c = beat.restart ? '0 : vstart_r;
    vlast_c  = beat.restart ? '0 : vlast_r;
  end

  assign vdiff = pos_c - vstart_c;
  assign vspan = vlast_c - vstart_c + 16'd1;

  always_comb begin
    phase_nxt  = phase_c;
    pos_nxt    = pos_c;
    kstart_nxt = kstart_c;
    kcount_nxt = kcount_c;
    vstart_nxt = vstart_c;
    vlast_nxt  = vlast_c;
    res        = '0;

    if (phase_c == PH_ERROR) begin
      phase_nxt = PH_ERROR;
    end else if (pos_c == BLOCK_LIMIT) begin
      res.valid = 1'b1;
      res.kind  = KIND_BLOCK;
      phase_nxt = PH_ERROR;
    end else begin
      pos_nxt = pos_c + 16'd1;
      unique case (phase_c)
        PH_LEAD: begin
          if (is_lf) begin
            res.valid          = 1'b1;
            res.kind           = KIND_END;
            res.consumed_count = pos_c + 16'd1;
            phase_nxt          = PH_LEAD;
            pos_nxt            = '0;
            kstart_nxt         = '0;
            kcount_nxt         = '0;
            vstart_nxt         = '0;
            vlast_nxt          = '0;
          end else if (!is_ws) begin
            kstart_nxt = pos_c;
            if (is_colon) begin
              kcount_nxt = '0;
              phase_nxt  = PH_PREVALUE;
            end else if (limit == '0) begin
              res.valid = 1'b1;
              res.kind  = KIND_LONG;
              phase_nxt = PH_ERROR;
            end else begin
              kcount_nxt = 9'd1;
              phase_nxt  = PH_KEY;
            end
          end
        end
        PH_KEY: begin
          if (is_lf) begin
            res.valid = 1'b1;
            res.kind  = KIND_SYNTAX;
            phase_nxt = PH_ERROR;
          end else if (is_colon) begin
            phase_nxt = PH_PREVALUE;
          end else if (is_ws) begin
            phase_nxt = PH_PRECOLON;
          end else if (kcount_c >= limit) begin
            res.valid = 1'b1;
            res.kind  = KIND_LONG;
            phase_nxt = PH_ERROR;
          end else begin
            kcount_nxt = kcount_c + 9'd1;
          end
        end
        PH_PRECOLON: begin
          if (is_colon) begin
            phase_nxt = PH_PREVALUE;
          end else if (is_lf || !is_ws) begin
            res.valid = 1'b1;
            res.kind  = KIND_SYNTAX;
            phase_nxt = PH_ERROR;
          end
        end
        PH_PREVALUE: begin
          if (is_lf) begin
            res.valid = 1'b1;
            res.kind  = KIND_SYNTAX;
            phase_nxt = PH_ERROR;
          end else if (!is_ws) begin
            if (limit == '0) begin
              res.valid = 1'b1;
              res.kind  = KIND_LONG;
              phase_nxt = PH_ERROR;
            end else begin
              vstart_nxt = pos_c;
              vlast_nxt  = pos_c;
              phase_nxt  = PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          if (is_lf) begin
            res.valid        = 1'b1;
            res.kind         = KIND_FIELD;
            res.key_offset   = kstart_c;
            res.key_length   = kcount_c;
            res.value_offset = vstart_c;
            res.value_length = vspan[LEN_W-1:0];
            phase_nxt        = PH_LEAD;
            kstart_nxt       = '0;
            kcount_nxt       = '0;
            vstart_nxt       = '0;
            vlast_nxt        = '0;
          end else if (!is_ws) begin
            if (vdiff >= {{(POS_W-LEN_W){1'b0}}, limit}) begin
              res.valid = 1'b1;
              res.kind  = KIND_LONG;
              phase_nxt = PH_ERROR;
            end else begin
              vlast_nxt = pos_c;
            end
          end
        end
        default: begin
          phase_nxt = PH_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEAD;
      pos_r    <= '0;
      kstart_r <= '0;
      kcount_r <= '0;
      vstart_r <= '0;
      vlast_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      kstart_r <= kstart_nxt;
      kcount_r <= kcount_nxt;
      vstart_r <= vstart_nxt;
      vlast_r  <= vlast_nxt;
    end
  end

endmodule

FILE: rtl/core/htok_out_stage.sv
module htok_out_stage import htok_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  res_t             res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output kind_t            out_kind,
  output logic [POS_W-1:0] out_key_offset,
  output logic [LEN_W-1:0] out_key_length,
  output logic [POS_W-1:0] out_value_offset,
  output logic [LEN_W-1:0] out_value_length,
  output logic [POS_W-1:0] out_consumed_count
);

  logic v_r;
  logic v_nxt;
  logic load;
  res_t res_r;

  assign free  = !v_r || !out_stall;
  assign load  = adv && res.valid;
  assign v_nxt = load || (v_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid          = v_r;
  assign out_kind           = res_r.kind;
  assign out_key_offset     = res_r.key_offset;
  assign out_key_length     = res_r.key_length;
  assign out_value_offset   = res_r.value_offset;
  assign out_value_length   = res_r.value_length;
  assign out_consumed_count = res_r.consumed_count;

endmodule

FILE: rtl/core/http_header_field_tokenizer.sv
// Path from input beat to result beat: the input register, then the result register.
// Throughput: one byte per cycle while no result beat is stalled; the parse state advances on each accepted byte.
// A byte waits in the input register only while a result beat is stalled.
// Reset (rst_n low, synchronous): parse state, position and valids cleared;
// max_field_length returns to 511.
`include "http_header_field_tokenizer_macros.svh"

module http_header_field_tokenizer import htok_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_restart,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_kind,
  output logic [POS_W-1:0] out_key_offset,
  output logic [LEN_W-1:0] out_key_length,
  output logic [POS_W-1:0] out_value_offset,
  output logic [LEN_W-1:0] out_value_length,
  output logic [POS_W-1:0] out_consumed_count,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  logic [LEN_W-1:0] max_len_r;
  beat_t            beat;
  res_t             res;
  logic             free;
  logic             adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_FIELD_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  assign adv = beat.valid && free;

  htok_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_restart   (in_restart),
    .adv          (adv),
    .beat         (beat)
  );

  htok_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .beat  (beat),
    .limit (max_len_r),
    .res   (res)
  );

  htok_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .adv                (adv),
    .res                (res),
    .free               (free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_key_offset     (out_key_offset),
    .out_key_length     (out_key_length),
    .out_value_offset   (out_value_offset),
    .out_value_length   (out_value_length),
    .out_consumed_count (out_consumed_count)
  );

  // input side only backs up behind a stalled result
  `HTOK_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a stalled result")
  `HTOK_ASSERT_NEXT(a_result_loaded, clk, rst_n, adv && res.valid, out_valid, "result lost at output register")
  `HTOK_ASSERT_IMPL(a_field_nonempty, clk, rst_n, out_valid && (out_kind == KIND_FIELD), out_value_length != '0, "field beat with empty value")
  `HTOK_ASSERT_IMPL(a_end_clean, clk, rst_n, out_valid && (out_kind == KIND_END), (out_key_length == '0) && (out_value_length == '0) && (out_consumed_count != '0), "end beat carries field data")

endmodule
